@@ src/mandelbrot_escape_time_pixel_top_assert.svh @@
// Assertion macros for the escape-time pixel block checks.
// Both sample on clk and are disabled while rst_n is low.
`ifndef MANDELBROT_ESCAPE_TIME_PIXEL_TOP_ASSERT_SVH
`define MANDELBROT_ESCAPE_TIME_PIXEL_TOP_ASSERT_SVH

// same-cycle implication
`define MBET_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mbet port check failed");

// next-cycle implication
`define MBET_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mbet port check failed");

`endif

@@ src/mbet_pkg.sv @@
package mbet_pkg;

    localparam int FRAC_BITS    = 27;
    localparam int COORD_W      = 32;
    localparam int IDX_W        = 12;
    localparam int DIM_W        = 13;
    localparam int ITER_W       = 10;
    localparam int SHADE_W      = 8;
    localparam int RANGE_W      = COORD_W + 1;
    localparam int PROD_W       = RANGE_W + IDX_W;
    localparam int REM_W        = DIM_W;
    localparam int STEP_W       = 6;
    localparam int SQ_W         = 2 * COORD_W;
    localparam int SAT_W        = 48;
    localparam int SHADE_PROD_W = ITER_W + SHADE_W;
    localparam int ADDR_W       = 5;
    localparam int DATA_W       = 32;
    localparam int REG_IDX_W    = 3;

    localparam logic [DIM_W-1:0]  MAX_DIM     = DIM_W'(4096);
    localparam logic [SQ_W-1:0]   ESC_BOUND   = SQ_W'(4) << (2 * FRAC_BITS);
    localparam logic [STEP_W-1:0] MAP_STEPS   = STEP_W'(PROD_W);
    localparam logic [STEP_W-1:0] SHADE_STEPS = STEP_W'(SHADE_PROD_W);

    localparam logic signed [SAT_W-1:0]   SAT_HI   = 48'sh0000_7FFF_FFFF;
    localparam logic signed [SAT_W-1:0]   SAT_LO   = 48'shFFFF_8000_0000;
    localparam logic signed [COORD_W-1:0] COORD_HI = 32'sh7FFF_FFFF;
    localparam logic signed [COORD_W-1:0] COORD_LO = 32'sh8000_0000;

    localparam logic [REG_IDX_W-1:0] REG_X_START  = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_X_END    = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_Y_START  = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_Y_END    = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_WIDTH    = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_HEIGHT   = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_MAX_ITER = 3'd6;

    typedef struct packed {
        logic [IDX_W-1:0] column;
        logic [IDX_W-1:0] row;
    } pixel_t;

    typedef struct packed {
        logic [IDX_W-1:0]   pixel_column;
        logic [IDX_W-1:0]   pixel_row;
        logic               drawn;
        logic [ITER_W-1:0]  iterations;
        logic [SHADE_W-1:0] shade;
    } result_t;

    typedef struct packed {
        logic [IDX_W-1:0]          column;
        logic [IDX_W-1:0]          row;
        logic signed [COORD_W-1:0] x0;
        logic signed [COORD_W-1:0] y0;
    } job_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] x_start;
        logic signed [COORD_W-1:0] x_end;
        logic signed [COORD_W-1:0] y_start;
        logic signed [COORD_W-1:0] y_end;
        logic [DIM_W-1:0]          image_width;
        logic [DIM_W-1:0]          image_height;
        logic [ITER_W-1:0]         max_iteration;
    } cfg_t;

    function automatic logic signed [COORD_W-1:0] sat32(input logic signed [SAT_W-1:0] v);
        logic signed [COORD_W-1:0] r;
        if (v > SAT_HI)
            r = COORD_HI;
        else if (v < SAT_LO)
            r = COORD_LO;
        else
            r = v[COORD_W-1:0];
        return r;
    endfunction

    function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] d);
        logic [DIM_W-1:0] r;
        if (d == '0)
            r = DIM_W'(1);
        else if (d > MAX_DIM)
            r = MAX_DIM;
        else
            r = d;
        return r;
    endfunction

    function automatic logic [ITER_W-1:0] eff_lim(input logic [ITER_W-1:0] m);
        logic [ITER_W-1:0] r;
        r = (m == '0) ? ITER_W'(1) : m;
        return r;
    endfunction

endpackage

@@ src/mbet_div.sv @@
module mbet_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [mbet_pkg::PROD_W-1:0]   dividend,
    input  logic [mbet_pkg::DIM_W-1:0]    divisor,
    input  logic [mbet_pkg::STEP_W-1:0]   steps,
    output logic                          busy,
    output logic [mbet_pkg::PROD_W-1:0]   quotient
);

    // Restoring divider, one quotient bit per cycle. The dividend is loaded
    // left-aligned to the step count, so after the last step the work
    // register holds the quotient alone.
    logic                          busy_reg, busy_next;
    logic [mbet_pkg::STEP_W-1:0]   cnt_reg, cnt_next;
    logic [mbet_pkg::PROD_W-1:0]   work_reg, work_next;
    logic [mbet_pkg::REM_W-1:0]    rem_reg, rem_next;
    logic [mbet_pkg::DIM_W-1:0]    dsr_reg, dsr_next;
    logic [mbet_pkg::REM_W:0]      trial;
    logic [mbet_pkg::REM_W:0]      diff;
    logic                          fits;

    always_comb
    begin
        trial     = {rem_reg, work_reg[mbet_pkg::PROD_W-1]};
        diff      = trial - {1'b0, dsr_reg};
        fits      = (trial >= {1'b0, dsr_reg});
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        work_next = work_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = steps;
            work_next = dividend;
            rem_next  = '0;
            dsr_next  = divisor;
        end
        else if (busy_reg)
        begin
            work_next = {work_reg[mbet_pkg::PROD_W-2:0], fits};
            rem_next  = fits ? diff[mbet_pkg::REM_W-1:0] : trial[mbet_pkg::REM_W-1:0];
            cnt_next  = cnt_reg - mbet_pkg::STEP_W'(1);
            if (cnt_reg == mbet_pkg::STEP_W'(1))
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            busy_reg <= 1'b0;
        else
            busy_reg <= busy_next;
    end

    always_ff @(posedge clk)
    begin
        cnt_reg  <= cnt_next;
        work_reg <= work_next;
        rem_reg  <= rem_next;
        dsr_reg  <= dsr_next;
    end

    assign busy     = busy_reg;
    assign quotient = work_reg;

endmodule

@@ src/mbet_front.sv @@
module mbet_front (
    input  logic              clk,
    input  logic              rst_n,
    input  mbet_pkg::cfg_t    cfg,
    input  logic              push,
    output logic              full,
    input  mbet_pkg::pixel_t  pixel,
    output logic              q_push,
    output mbet_pkg::job_t    q_data,
    input  logic              q_full
);

    localparam logic [2:0] F_IDLE  = 3'd0;
    localparam logic [2:0] F_MUL   = 3'd1;
    localparam logic [2:0] F_START = 3'd2;
    localparam logic [2:0] F_DIV   = 3'd3;
    localparam logic [2:0] F_SUM   = 3'd4;

    logic [2:0]                           state_reg, state_next;
    mbet_pkg::pixel_t                     pix_reg, pix_next;
    logic signed [mbet_pkg::PROD_W-1:0]   prod_x_reg, prod_x_next;
    logic signed [mbet_pkg::PROD_W-1:0]   prod_y_reg, prod_y_next;

    logic signed [mbet_pkg::RANGE_W-1:0]  range_x, range_y;
    logic signed [mbet_pkg::IDX_W:0]      idx_x, idx_y;
    logic signed [mbet_pkg::PROD_W-1:0]   mul_x, mul_y;
    logic [mbet_pkg::PROD_W-1:0]          mag_x, mag_y;
    logic [mbet_pkg::PROD_W-1:0]          quot_x, quot_y;
    logic                                 busy_x, busy_y;
    logic                                 div_start;
    logic signed [mbet_pkg::SAT_W-1:0]    q_x, q_y, sum_x, sum_y;

    assign range_x = $signed({cfg.x_end[mbet_pkg::COORD_W-1], cfg.x_end})
                   - $signed({cfg.x_start[mbet_pkg::COORD_W-1], cfg.x_start});
    assign range_y = $signed({cfg.y_end[mbet_pkg::COORD_W-1], cfg.y_end})
                   - $signed({cfg.y_start[mbet_pkg::COORD_W-1], cfg.y_start});
    assign idx_x   = $signed({1'b0, pix_reg.column});
    assign idx_y   = $signed({1'b0, pix_reg.row});
    assign mul_x   = range_x * idx_x;
    assign mul_y   = range_y * idx_y;

    // divide magnitudes, sign restored afterwards: truncation toward zero
    assign mag_x = prod_x_reg[mbet_pkg::PROD_W-1] ? $unsigned(-prod_x_reg) : $unsigned(prod_x_reg);
    assign mag_y = prod_y_reg[mbet_pkg::PROD_W-1] ? $unsigned(-prod_y_reg) : $unsigned(prod_y_reg);
    assign div_start = (state_reg == F_START);

    mbet_div u_div_x (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (mag_x),
        .divisor  (mbet_pkg::eff_dim(cfg.image_width)),
        .steps    (mbet_pkg::MAP_STEPS),
        .busy     (busy_x),
        .quotient (quot_x)
    );

    mbet_div u_div_y (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (mag_y),
        .divisor  (mbet_pkg::eff_dim(cfg.image_height)),
        .steps    (mbet_pkg::MAP_STEPS),
        .busy     (busy_y),
        .quotient (quot_y)
    );

    always_comb
    begin
        q_x = $signed({{(mbet_pkg::SAT_W-mbet_pkg::PROD_W){1'b0}}, quot_x});
        q_y = $signed({{(mbet_pkg::SAT_W-mbet_pkg::PROD_W){1'b0}}, quot_y});
        if (prod_x_reg[mbet_pkg::PROD_W-1])
            q_x = -q_x;
        if (prod_y_reg[mbet_pkg::PROD_W-1])
            q_y = -q_y;
        sum_x = q_x + mbet_pkg::SAT_W'(cfg.x_start);
        sum_y = q_y + mbet_pkg::SAT_W'(cfg.y_start);
    end

    always_comb
    begin
        state_next    = state_reg;
        pix_next      = pix_reg;
        prod_x_next   = prod_x_reg;
        prod_y_next   = prod_y_reg;
        q_push        = 1'b0;
        q_data.column = pix_reg.column;
        q_data.row    = pix_reg.row;
        q_data.x0     = mbet_pkg::sat32(sum_x);
        q_data.y0     = mbet_pkg::sat32(sum_y);
        case (state_reg)
            F_IDLE:
            begin
                if (push)
                begin
                    pix_next   = pixel;
                    state_next = F_MUL;
                end
            end
            F_MUL:
            begin
                prod_x_next = mul_x;
                prod_y_next = mul_y;
                state_next  = F_START;
            end
            F_START:
            begin
                state_next = F_DIV;
            end
            F_DIV:
            begin
                if (!busy_x && !busy_y)
                    state_next = F_SUM;
            end
            F_SUM:
            begin
                if (!q_full)
                begin
                    q_push     = 1'b1;
                    state_next = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    assign full = (state_reg != F_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= F_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        pix_reg    <= pix_next;
        prod_x_reg <= prod_x_next;
        prod_y_reg <= prod_y_next;
    end

endmodule

@@ src/mbet_fifo.sv @@
module mbet_fifo (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            wr,
    input  mbet_pkg::job_t  wdata,
    output logic            full,
    input  logic            rd,
    output mbet_pkg::job_t  rdata,
    output logic            empty
);

    // two-entry queue between coordinate mapping and the iteration engine
    mbet_pkg::job_t mem_reg [2];
    logic           wr_ptr_reg, wr_ptr_next;
    logic           rd_ptr_reg, rd_ptr_next;
    logic [1:0]     count_reg, count_next;
    logic           do_wr, do_rd;

    assign full  = (count_reg == 2'd2);
    assign empty = (count_reg == 2'd0);
    assign do_wr = wr && !full;
    assign do_rd = rd && !empty;
    assign rdata = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ do_wr;
        rd_ptr_next = rd_ptr_reg ^ do_rd;
        count_next  = count_reg + {1'b0, do_wr} - {1'b0, do_rd};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem_reg[wr_ptr_reg] <= wdata;
    end

endmodule

@@ src/mbet_back.sv @@
module mbet_back (
    input  logic              clk,
    input  logic              rst_n,
    input  mbet_pkg::cfg_t    cfg,
    input  logic              q_empty,
    input  mbet_pkg::job_t    q_data,
    output logic              q_pop,
    output logic              empty,
    input  logic              pop,
    output mbet_pkg::result_t result
);

    localparam logic [2:0] B_IDLE  = 3'd0;
    localparam logic [2:0] B_MUL   = 3'd1;
    localparam logic [2:0] B_TEST  = 3'd2;
    localparam logic [2:0] B_SHADE = 3'd3;
    localparam logic [2:0] B_WAIT  = 3'd4;
    localparam logic [2:0] B_OUT   = 3'd5;

    logic [2:0]                           state_reg, state_next;
    mbet_pkg::job_t                       job_reg, job_next;
    logic signed [mbet_pkg::COORD_W-1:0]  x_reg, x_next, y_reg, y_next;
    logic [mbet_pkg::ITER_W-1:0]          n_reg, n_next;
    logic signed [mbet_pkg::SQ_W-1:0]     xx_reg, xx_next, yy_reg, yy_next, xy_reg, xy_next;
    mbet_pkg::result_t                    res_reg, res_next;
    logic                                 res_valid_reg, res_valid_next;

    logic [mbet_pkg::ITER_W-1:0]          lim;
    logic signed [mbet_pkg::SQ_W-1:0]     mul_xx, mul_yy, mul_xy, diff_sq;
    logic [mbet_pkg::SQ_W-1:0]            sum_sq;
    logic                                 go;
    logic signed [mbet_pkg::SAT_W-1:0]    nx_sum, ny_sum;
    logic [mbet_pkg::SHADE_PROD_W-1:0]    shade_prod;
    logic [mbet_pkg::PROD_W-1:0]          shade_dividend;
    logic [mbet_pkg::PROD_W-1:0]          quot;
    logic                                 div_busy;
    logic                                 div_start;

    assign lim    = mbet_pkg::eff_lim(cfg.max_iteration);
    assign mul_xx = x_reg * x_reg;
    assign mul_yy = y_reg * y_reg;
    assign mul_xy = x_reg * y_reg;

    // squares are non-negative and at most 2^62, so the sum cannot wrap
    assign sum_sq  = $unsigned(xx_reg) + $unsigned(yy_reg);
    assign go      = (n_reg < lim) && (sum_sq <= mbet_pkg::ESC_BOUND);
    assign diff_sq = xx_reg - yy_reg;
    assign nx_sum  = mbet_pkg::SAT_W'(diff_sq >>> mbet_pkg::FRAC_BITS)
                   + mbet_pkg::SAT_W'(job_reg.x0);
    // 2*x*y: shift one less
    assign ny_sum  = mbet_pkg::SAT_W'(xy_reg >>> (mbet_pkg::FRAC_BITS - 1))
                   + mbet_pkg::SAT_W'(job_reg.y0);

    // 255*n = 256*n - n, left-aligned for an 18-step division
    assign shade_prod     = mbet_pkg::SHADE_PROD_W'({n_reg, 8'd0})
                          - mbet_pkg::SHADE_PROD_W'(n_reg);
    assign shade_dividend = {shade_prod, {(mbet_pkg::PROD_W-mbet_pkg::SHADE_PROD_W){1'b0}}};
    assign div_start      = (state_reg == B_SHADE);

    mbet_div u_div_shade (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (shade_dividend),
        .divisor  (mbet_pkg::DIM_W'(lim)),
        .steps    (mbet_pkg::SHADE_STEPS),
        .busy     (div_busy),
        .quotient (quot)
    );

    always_comb
    begin
        state_next     = state_reg;
        job_next       = job_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        n_next         = n_reg;
        xx_next        = xx_reg;
        yy_next        = yy_reg;
        xy_next        = xy_reg;
        res_next       = res_reg;
        res_valid_next = res_valid_reg;
        q_pop          = 1'b0;
        if (pop && res_valid_reg)
            res_valid_next = 1'b0;
        case (state_reg)
            B_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop      = 1'b1;
                    job_next   = q_data;
                    x_next     = '0;
                    y_next     = '0;
                    n_next     = '0;
                    state_next = B_MUL;
                end
            end
            B_MUL:
            begin
                xx_next    = mul_xx;
                yy_next    = mul_yy;
                xy_next    = mul_xy;
                state_next = B_TEST;
            end
            B_TEST:
            begin
                if (go)
                begin
                    x_next     = mbet_pkg::sat32(nx_sum);
                    y_next     = mbet_pkg::sat32(ny_sum);
                    n_next     = n_reg + mbet_pkg::ITER_W'(1);
                    state_next = B_MUL;
                end
                else
                begin
                    state_next = B_SHADE;
                end
            end
            B_SHADE:
            begin
                state_next = B_WAIT;
            end
            B_WAIT:
            begin
                if (!div_busy)
                    state_next = B_OUT;
            end
            B_OUT:
            begin
                if (!res_valid_reg || pop)
                begin
                    res_next.pixel_column = job_reg.column;
                    res_next.pixel_row    = job_reg.row;
                    res_next.drawn        = (n_reg != lim);
                    res_next.iterations   = n_reg;
                    res_next.shade        = quot[mbet_pkg::SHADE_W-1:0];
                    res_valid_next        = 1'b1;
                    state_next            = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    assign empty  = !res_valid_reg;
    assign result = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg <= job_next;
        x_reg   <= x_next;
        y_reg   <= y_next;
        n_reg   <= n_next;
        xx_reg  <= xx_next;
        yy_reg  <= yy_next;
        xy_reg  <= xy_next;
        res_reg <= res_next;
    end

endmodule

@@ src/mandelbrot_escape_time_pixel_top.sv @@
// Mandelbrot escape-time pixel evaluator.
// Input queue: drive pixel (column, row) and raise push; the item is taken on a
// clock edge where push is high and full is low. Result queue: while empty is low
// the oldest result (pixel_column, pixel_row, drawn, iterations, shade) is on
// result; raise pop to take it. Results leave in input order, one per item.
// The front maps a pixel into the window: a multiply state, then two 45-step restoring
// dividers in parallel; it takes no new pixel until the current one is handed to the
// queue. A two-item queue feeds the back, which iterates z = z*z + c through three
// 32x32 multipliers, a multiply and a test state per iteration, then an 18-step divider
// forms the shade. The slower of front and back sets the sustained rate; the front maps
// the next pixels meanwhile. If the receiver stalls, one result waits in the output
// register, the back holds its next finished result, then the queue and the front fill
// up and full stays high. Reset empties every stage and loads the window -2.5..1.0 by
// -1.0..1.0, 1000 x 600 pixels and a limit of 50. Configuration registers sit on the
// APB port at byte address 4*index; the user must write them only while idle, and the
// block itself does not enforce this.
module mandelbrot_escape_time_pixel_top (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [mbet_pkg::ADDR_W-1:0]    paddr,
    input  logic [mbet_pkg::DATA_W-1:0]    pwdata,
    output logic [mbet_pkg::DATA_W-1:0]    prdata,
    output logic                           pready,
    input  logic                           push,
    output logic                           full,
    input  mbet_pkg::pixel_t               pixel,
    output logic                           empty,
    input  logic                           pop,
    output mbet_pkg::result_t              result
);

    mbet_pkg::cfg_t                    cfg_reg, cfg_next;
    logic [mbet_pkg::REG_IDX_W-1:0]    reg_idx;
    logic                              wr_en;
    logic                              q_push, q_full, q_pop, q_empty;
    mbet_pkg::job_t                    q_wdata, q_rdata;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = paddr[mbet_pkg::ADDR_W-1:2];

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (reg_idx)
                mbet_pkg::REG_X_START:  cfg_next.x_start       = pwdata;
                mbet_pkg::REG_X_END:    cfg_next.x_end         = pwdata;
                mbet_pkg::REG_Y_START:  cfg_next.y_start       = pwdata;
                mbet_pkg::REG_Y_END:    cfg_next.y_end         = pwdata;
                mbet_pkg::REG_WIDTH:    cfg_next.image_width   = pwdata[mbet_pkg::DIM_W-1:0];
                mbet_pkg::REG_HEIGHT:   cfg_next.image_height  = pwdata[mbet_pkg::DIM_W-1:0];
                mbet_pkg::REG_MAX_ITER: cfg_next.max_iteration = pwdata[mbet_pkg::ITER_W-1:0];
                default:                cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            mbet_pkg::REG_X_START:  prdata = cfg_reg.x_start;
            mbet_pkg::REG_X_END:    prdata = cfg_reg.x_end;
            mbet_pkg::REG_Y_START:  prdata = cfg_reg.y_start;
            mbet_pkg::REG_Y_END:    prdata = cfg_reg.y_end;
            mbet_pkg::REG_WIDTH:    prdata = mbet_pkg::DATA_W'(cfg_reg.image_width);
            mbet_pkg::REG_HEIGHT:   prdata = mbet_pkg::DATA_W'(cfg_reg.image_height);
            mbet_pkg::REG_MAX_ITER: prdata = mbet_pkg::DATA_W'(cfg_reg.max_iteration);
            default:                prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.x_start       <= 32'shEC00_0000;
            cfg_reg.x_end         <= 32'sh0800_0000;
            cfg_reg.y_start       <= 32'shF800_0000;
            cfg_reg.y_end         <= 32'sh0800_0000;
            cfg_reg.image_width   <= mbet_pkg::DIM_W'(1000);
            cfg_reg.image_height  <= mbet_pkg::DIM_W'(600);
            cfg_reg.max_iteration <= mbet_pkg::ITER_W'(50);
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    mbet_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_reg),
        .push   (push),
        .full   (full),
        .pixel  (pixel),
        .q_push (q_push),
        .q_data (q_wdata),
        .q_full (q_full)
    );

    mbet_fifo u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (q_push),
        .wdata (q_wdata),
        .full  (q_full),
        .rd    (q_pop),
        .rdata (q_rdata),
        .empty (q_empty)
    );

    mbet_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .q_empty (q_empty),
        .q_data  (q_rdata),
        .q_pop   (q_pop),
        .empty   (empty),
        .pop     (pop),
        .result  (result)
    );

endmodule

@@ src/mbet_checker.sv @@
`include "mandelbrot_escape_time_pixel_top_assert.svh"

module mbet_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              pop,
    input logic              empty,
    input mbet_pkg::result_t result
);

    // a waiting result is neither dropped nor altered
    `MBET_ASSERT_NEXT(a_result_held, !empty && !pop, !empty)
    `MBET_ASSERT_NEXT(a_result_stable, !empty && !pop, $stable(result))
    // only points that hit the limit get full shade
    `MBET_ASSERT_NOW(a_drawn_shade, !empty, result.drawn == (result.shade != 8'd255))
    // the origin is always inside the bound, so at least one iteration runs
    `MBET_ASSERT_NOW(a_iter_nonzero, !empty, result.iterations != 10'd0)

endmodule

bind mandelbrot_escape_time_pixel_top mbet_checker u_mbet_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .pop    (pop),
    .empty  (empty),
    .result (result)
);

@@ dv/testbench.sv @@
module testbench;
    import mbet_pkg::*;

    localparam int Q_FRAC = 27;
    localparam longint unsigned ESCAPE_R2 = 64'd4 << (2 * Q_FRAC);
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES = 300;
    localparam int HOLD_CYCLES = 1000;
    localparam int NUM_PHASES = 14;
    localparam int DIR_ROWS = 29;
    localparam logic [REG_IDX_W-1:0] REG_UNUSED = 3'd7;

    localparam cfg_t HOME_WINDOW = '{x_start: -335544320, x_end: 134217728,
                                     y_start: -134217728, y_end: 134217728,
                                     image_width: 1000, image_height: 600,
                                     max_iteration: 50};

    // one directed step: a register write or a pixel, with an optional typed result
    typedef struct {
        bit                   cfg_write;
        logic [REG_IDX_W-1:0] idx;
        logic [31:0]          val;
        logic [IDX_W-1:0]     col;
        logic [IDX_W-1:0]     row;
        bit                   typed;
        logic                 drawn;
        logic [ITER_W-1:0]    iters;
        logic [SHADE_W-1:0]   shade;
    } stim_row_t;

    stim_row_t dir_tab [DIR_ROWS] = '{
        // reset window: corners escape at once, -0.4 on the real axis stays inside
        '{1'b0, REG_UNUSED, 32'd0, 12'd0,    12'd0,    1'b1, 1'b1, 10'd1,    8'd5},
        '{1'b0, REG_UNUSED, 32'd0, 12'd4095, 12'd4095, 1'b1, 1'b1, 10'd1,    8'd5},
        '{1'b0, REG_UNUSED, 32'd0, 12'd600,  12'd300,  1'b1, 1'b0, 10'd50,   8'd255},
        '{1'b0, REG_UNUSED, 32'd0, 12'd0,    12'd4095, 1'b1, 1'b1, 10'd1,    8'd5},
        '{1'b0, REG_UNUSED, 32'd0, 12'd4095, 12'd0,    1'b1, 1'b1, 10'd1,    8'd5},
        '{1'b0, REG_UNUSED, 32'd0, 12'd999,  12'd599,  1'b0, 1'b0, 10'd0,    8'd0},
        '{1'b0, REG_UNUSED, 32'd0, 12'd1000, 12'd600,  1'b0, 1'b0, 10'd0,    8'd0},
        '{1'b0, REG_UNUSED, 32'd0, 12'd2048, 12'd2048, 1'b0, 1'b0, 10'd0,    8'd0},
        '{1'b0, REG_UNUSED, 32'd0, 12'd2730, 12'd1365, 1'b0, 1'b0, 10'd0,    8'd0},
        '{1'b0, REG_UNUSED, 32'd0, 12'd1365, 12'd2730, 1'b0, 1'b0, 10'd0,    8'd0},
        // limit of zero behaves as one
        '{1'b1, REG_MAX_ITER, 32'd0, 12'd0,  12'd0,    1'b0, 1'b0, 10'd0,    8'd0},
        '{1'b0, REG_UNUSED, 32'd0, 12'd600,  12'd300,  1'b1, 1'b0, 10'd1,    8'd255},
        '{1'b0, REG_UNUSED, 32'd0, 12'd0,    12'd0,    1'b1, 1'b0, 10'd1,    8'd255},
        // full limit on an inside point
        '{1'b1, REG_MAX_ITER, 32'd1023, 12'd0, 12'd0,  1'b0, 1'b0, 10'd0,    8'd0},
        '{1'b0, REG_UNUSED, 32'd0, 12'd600,  12'd300,  1'b1, 1'b0, 10'd1023, 8'd255},
        '{1'b0, REG_UNUSED, 32'd0, 12'd300,  12'd150,  1'b0, 1'b0, 10'd0,    8'd0},
        // widest window; width masks to zero, height above the maximum
        '{1'b1, REG_X_START, 32'h8000_0000, 12'd0, 12'd0, 1'b0, 1'b0, 10'd0, 8'd0},
        '{1'b1, REG_X_END,   32'h7FFF_FFFF, 12'd0, 12'd0, 1'b0, 1'b0, 10'd0, 8'd0},
        '{1'b1, REG_Y_START, 32'h8000_0000, 12'd0, 12'd0, 1'b0, 1'b0, 10'd0, 8'd0},
        '{1'b1, REG_Y_END,   32'h7FFF_FFFF, 12'd0, 12'd0, 1'b0, 1'b0, 10'd0, 8'd0},
        '{1'b1, REG_WIDTH,   32'hFFFF_E000, 12'd0, 12'd0, 1'b0, 1'b0, 10'd0, 8'd0},
        '{1'b1, REG_HEIGHT,  32'd8191,      12'd0, 12'd0, 1'b0, 1'b0, 10'd0, 8'd0},
        '{1'b1, REG_MAX_ITER, 32'd20,       12'd0, 12'd0, 1'b0, 1'b0, 10'd0, 8'd0},
        '{1'b0, REG_UNUSED, 32'd0, 12'd0,    12'd0,    1'b1, 1'b1, 10'd1,    8'd12},
        '{1'b0, REG_UNUSED, 32'd0, 12'd4095, 12'd4095, 1'b0, 1'b0, 10'd0,    8'd0},
        '{1'b0, REG_UNUSED, 32'd0, 12'd1,    12'd1,    1'b0, 1'b0, 10'd0,    8'd0},
        '{1'b0, REG_UNUSED, 32'd0, 12'd2048, 12'd1,    1'b0, 1'b0, 10'd0,    8'd0},
        // write to an unmapped index must change nothing
        '{1'b1, REG_UNUSED, 32'h1234_5678, 12'd0, 12'd0, 1'b0, 1'b0, 10'd0, 8'd0},
        '{1'b0, REG_UNUSED, 32'd0, 12'd4095, 12'd0,    1'b0, 1'b0, 10'd0,    8'd0}
    };

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [ADDR_W-1:0]   paddr = '0;
    logic [DATA_W-1:0]   pwdata = '0;
    logic [DATA_W-1:0]   prdata;
    logic                pready;
    logic                push = 1'b0;
    logic                full;
    pixel_t              pixel = '0;
    logic                empty;
    logic                pop = 1'b0;
    result_t             result;

    cfg_t    win = HOME_WINDOW;
    result_t pending [$];
    int      errors = 0;
    int      stall_cycles = 0;
    bit      no_idle = 1'b0;
    bit      hold_req = 1'b0;

    mandelbrot_escape_time_pixel_top dut (
        .clk, .rst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
        .push, .full, .pixel, .empty, .pop, .result
    );

    always #5 clk = ~clk;

    function automatic longint clamp32(input longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint map_axis(input logic signed [COORD_W-1:0] lo,
                                        input logic signed [COORD_W-1:0] hi,
                                        input logic [IDX_W-1:0] idx,
                                        input logic [DIM_W-1:0] dim);
        longint d;
        d = (dim == 0) ? 1 : ((dim > 4096) ? 4096 : longint'(dim));
        // product exact, quotient truncated toward zero, then saturate
        return clamp32((longint'(hi) - longint'(lo)) * longint'(idx) / d + longint'(lo));
    endfunction

    function automatic result_t escape_time(input pixel_t px);
        result_t r;
        longint  x0, y0, x, y, nx;
        int      n, lim;
        lim = (win.max_iteration == 0) ? 1 : int'(win.max_iteration);
        x0 = map_axis(win.x_start, win.x_end, px.column, win.image_width);
        y0 = map_axis(win.y_start, win.y_end, px.row, win.image_height);
        x = 0;
        y = 0;
        n = 0;
        while (n < lim && ($unsigned(x * x) + $unsigned(y * y)) <= ESCAPE_R2) begin
            nx = clamp32(((x * x - y * y) >>> Q_FRAC) + x0);
            // 2xy: one less bit of rescale
            y = clamp32(((x * y) >>> (Q_FRAC - 1)) + y0);
            x = nx;
            n++;
        end
        r.pixel_column = px.column;
        r.pixel_row = px.row;
        r.drawn = (n != lim);
        r.iterations = ITER_W'(n);
        r.shade = SHADE_W'((255 * n) / lim);
        return r;
    endfunction

    // leaves the bus in the access phase; caller releases it
    task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [31:0] val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        case (idx)
            REG_X_START:  win.x_start = val;
            REG_X_END:    win.x_end = val;
            REG_Y_START:  win.y_start = val;
            REG_Y_END:    win.y_end = val;
            REG_WIDTH:    win.image_width = val[DIM_W-1:0];
            REG_HEIGHT:   win.image_height = val[DIM_W-1:0];
            REG_MAX_ITER: win.max_iteration = val[ITER_W-1:0];
            default:      ;
        endcase
    endtask

    task automatic load_window(input cfg_t c);
        write_reg(REG_X_START, c.x_start);
        write_reg(REG_X_END, c.x_end);
        write_reg(REG_Y_START, c.y_start);
        write_reg(REG_Y_END, c.y_end);
        // junk above the field width must be dropped
        write_reg(REG_WIDTH, ($urandom() & 32'hFFFF_E000) | 32'(c.image_width));
        write_reg(REG_HEIGHT, ($urandom() & 32'hFFFF_E000) | 32'(c.image_height));
        write_reg(REG_MAX_ITER, ($urandom() & 32'hFFFF_FC00) | 32'(c.max_iteration));
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    // push stays high after acceptance; the next call lowers it or offers the next item
    task automatic offer_pixel(input pixel_t px, input result_t want);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push <= 1'b1;
        pixel <= px;
        do @(posedge clk); while (full);
        pending.push_back(want);
    endtask

    initial begin : result_drain
        int gap;
        do @(posedge clk); while (!rst_n);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                pop <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            gap = no_idle ? 0 : $urandom_range(0, 3);
            if (gap > 0) begin
                pop <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            pop <= 1'b1;
            do @(posedge clk); while (empty);
        end
    end

    always @(posedge clk) begin
        result_t want;
        if (rst_n && pop && !empty) begin
            if (pending.size() == 0) begin
                $error("result for pixel (%0d,%0d) with no item outstanding",
                       result.pixel_column, result.pixel_row);
                errors++;
            end else begin
                want = pending.pop_front();
                if (result.pixel_column !== want.pixel_column) begin
                    $error("pixel_column: expected %0d, got %0d",
                           want.pixel_column, result.pixel_column);
                    errors++;
                end
                if (result.pixel_row !== want.pixel_row) begin
                    $error("pixel_row: expected %0d, got %0d", want.pixel_row, result.pixel_row);
                    errors++;
                end
                if (result.drawn !== want.drawn) begin
                    $error("drawn: expected %0d, got %0d", want.drawn, result.drawn);
                    errors++;
                end
                if (result.iterations !== want.iterations) begin
                    $error("iterations: expected %0d, got %0d",
                           want.iterations, result.iterations);
                    errors++;
                end
                if (result.shade !== want.shade) begin
                    $error("shade: expected %0d, got %0d", want.shade, result.shade);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (push && !full) || (pop && !empty) || (psel && penable))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    initial begin : stimulus
        pixel_t  px;
        result_t want;
        cfg_t    next_win;
        int      ph, k, n_items, w, h, cx, cy, span, flip;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < DIR_ROWS; i++) begin
            if (dir_tab[i].cfg_write) begin
                push <= 1'b0;
                while (pending.size() != 0) @(posedge clk);
                write_reg(dir_tab[i].idx, dir_tab[i].val);
            end else begin
                if (psel) begin
                    psel <= 1'b0;
                    penable <= 1'b0;
                end
                px.column = dir_tab[i].col;
                px.row = dir_tab[i].row;
                if (dir_tab[i].typed) begin
                    want.pixel_column = px.column;
                    want.pixel_row = px.row;
                    want.drawn = dir_tab[i].drawn;
                    want.iterations = dir_tab[i].iters;
                    want.shade = dir_tab[i].shade;
                end else begin
                    want = escape_time(px);
                end
                offer_pixel(px, want);
            end
        end

        for (ph = 0; ph < NUM_PHASES; ph++) begin
            push <= 1'b0;
            while (pending.size() != 0) @(posedge clk);
            next_win = HOME_WINDOW;
            case (ph)
                0: ;
                1: begin
                    // extreme edges, y axis reversed, single-iteration limit
                    next_win.x_start = 32'sh8000_0000;
                    next_win.x_end = 32'sh7FFF_FFFF;
                    next_win.y_start = 32'sh7FFF_FFFF;
                    next_win.y_end = 32'sh8000_0000;
                    next_win.image_width = 1;
                    next_win.image_height = 4096;
                    next_win.max_iteration = 1;
                end
                2: begin
                    next_win.image_width = 4096;
                    next_win.image_height = 1;
                    next_win.max_iteration = 1023;
                end
                default: begin
                    if ($urandom_range(0, 3) == 0) begin
                        next_win.x_start = $urandom();
                        next_win.x_end = $urandom();
                        next_win.y_start = $urandom();
                        next_win.y_end = $urandom();
                    end else begin
                        // window around the set, zoom from 2.0 down to 2^-11
                        cx = int'($urandom_range(0, 335544320)) - 268435456;
                        cy = int'($urandom_range(0, 322122547)) - 161061273;
                        span = 268435456 >>> $urandom_range(0, 12);
                        flip = ($urandom_range(0, 3) == 0) ? -1 : 1;
                        next_win.x_start = cx - flip * span;
                        next_win.x_end = cx + flip * span;
                        next_win.y_start = cy - span;
                        next_win.y_end = cy + span;
                    end
                    next_win.image_width = ($urandom_range(0, 3) == 0) ?
                        DIM_W'($urandom_range(0, 8191)) : DIM_W'($urandom_range(1, 64));
                    next_win.image_height = ($urandom_range(0, 3) == 0) ?
                        DIM_W'($urandom_range(0, 8191)) : DIM_W'($urandom_range(1, 64));
                    next_win.max_iteration = ($urandom_range(0, 9) == 0) ?
                        ITER_W'($urandom_range(0, 1023)) : ITER_W'($urandom_range(1, 64));
                end
            endcase
            load_window(next_win);
            if (ph == 0)
                hold_req = 1'b1;
            no_idle = (ph != 0) && ($urandom_range(0, 3) == 0);
            n_items = (next_win.max_iteration > 256) ? 12 : 50;
            w = (win.image_width == 0) ? 1 : ((win.image_width > 4096) ? 4096 : win.image_width);
            h = (win.image_height == 0) ? 1 :
                ((win.image_height > 4096) ? 4096 : win.image_height);
            for (k = 0; k < n_items; k++) begin
                // mostly inside the frame, sometimes anywhere on the index range
                px.column = ($urandom_range(0, 7) == 0) ?
                    IDX_W'($urandom_range(0, 4095)) : IDX_W'($urandom_range(0, w - 1));
                px.row = ($urandom_range(0, 7) == 0) ?
                    IDX_W'($urandom_range(0, 4095)) : IDX_W'($urandom_range(0, h - 1));
                offer_pixel(px, escape_time(px));
            end
        end

        push <= 1'b0;
        while (pending.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
